/* design/msld_pkg.sv */
// Types and constants shared by the mid/side stereo line decoder.
package msld_pkg;

    localparam int unsigned CoefW    = 32;
    localparam int unsigned BandW    = 6;
    localparam int unsigned ExpW     = 7;
    localparam int unsigned ExpOutW  = 8;
    localparam int unsigned CntW     = 7;
    localparam int unsigned ModeW    = 2;
    localparam int unsigned ShiftW   = 5;
    localparam int unsigned InDataW  = 88;
    localparam int unsigned OutDataW = 80;
    localparam int unsigned AddrW    = 4;
    localparam int unsigned ApbDataW = 32;

    localparam logic [ShiftW-1:0] ShiftMax = 5'd31;

    // register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_MS_BAND_LIMIT    = 2'd0,
        REG_LEFT_BANDS_SENT  = 2'd1,
        REG_RIGHT_BANDS_SENT = 2'd2,
        REG_MASK_MODE        = 2'd3
    } t_reg_idx;

    localparam logic [ModeW-1:0] MaskModeClear = 2'd2;

    typedef struct packed {
        logic [ExpW-1:0]         right_exp;
        logic [ExpW-1:0]         left_exp;
        logic [BandW-1:0]        band_index;
        logic signed [CoefW-1:0] right_in;
        logic signed [CoefW-1:0] left_in;
        logic                    ms_flag;
    } t_in_item;

    typedef struct packed {
        logic [ExpOutW-1:0]      right_exp_out;
        logic [ExpOutW-1:0]      left_exp_out;
        logic signed [CoefW-1:0] right_out;
        logic signed [CoefW-1:0] left_out;
        logic                    ms_flag_out;
    } t_out_item;

endpackage

/* design/ms_stereo_line_decode_top.sv */
// Mid/side stereo line decoder: one left/right spectral line pair per transfer.
//
// Each input transfer carries one line pair with its band index, both band
// exponents and the band's M/S flag; exactly one result transfer follows.
// Throughput is one line pair per clock unless the result side stalls. The
// result passes through the input register, then the result register; a
// stall on the result side holds both registers. The path between them is
// one exponent compare, a 32-bit arithmetic shifter per side and one 32-bit
// add/subtract. Band counts and the M/S limit are set through the APB port
// while the block is idle (user rule, not enforced by the block). Values above
// MAX_BANDS act as MAX_BANDS. Bands at or above MAX_BANDS pass unchanged.
module ms_stereo_line_decode_top #(
    parameter int unsigned MAX_BANDS = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // APB configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [msld_pkg::AddrW-1:0]         paddr,
    input  logic [msld_pkg::ApbDataW-1:0]      pwdata,
    output logic [msld_pkg::ApbDataW-1:0]      prdata,
    output logic                               pready,
    // input stream
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [31:0] left_in, [63:32] right_in, [69:64] band_index,
    // [76:70] left_exp, [83:77] right_exp, [87:84] zero
    input  logic [msld_pkg::InDataW-1:0]       i_s_axis_tdata,
    // [0] ms_flag
    input  logic                               i_s_axis_tuser,
    // result stream
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [31:0] left_out, [63:32] right_out, [71:64] left_exp_out,
    // [79:72] right_exp_out
    output logic [msld_pkg::OutDataW-1:0]      o_m_axis_tdata,
    // [0] ms_flag_out
    output logic                               o_m_axis_tuser
);

    localparam logic [msld_pkg::CntW-1:0] MaxBandsC = msld_pkg::CntW'(MAX_BANDS);

    // configuration registers
    logic [msld_pkg::CntW-1:0]  r_ms_band_limit;
    logic [msld_pkg::CntW-1:0]  r_left_bands_sent;
    logic [msld_pkg::CntW-1:0]  r_right_bands_sent;
    logic [msld_pkg::ModeW-1:0] r_mask_mode;

    logic            cfg_wr;
    msld_pkg::t_reg_idx cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = msld_pkg::t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ms_band_limit    <= '0;
            r_left_bands_sent  <= '0;
            r_right_bands_sent <= '0;
            r_mask_mode        <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                msld_pkg::REG_MS_BAND_LIMIT:    r_ms_band_limit    <= pwdata[msld_pkg::CntW-1:0];
                msld_pkg::REG_LEFT_BANDS_SENT:  r_left_bands_sent  <= pwdata[msld_pkg::CntW-1:0];
                msld_pkg::REG_RIGHT_BANDS_SENT: r_right_bands_sent <= pwdata[msld_pkg::CntW-1:0];
                msld_pkg::REG_MASK_MODE:        r_mask_mode        <= pwdata[msld_pkg::ModeW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            msld_pkg::REG_MS_BAND_LIMIT:
                prdata = {{(msld_pkg::ApbDataW-msld_pkg::CntW){1'b0}}, r_ms_band_limit};
            msld_pkg::REG_LEFT_BANDS_SENT:
                prdata = {{(msld_pkg::ApbDataW-msld_pkg::CntW){1'b0}}, r_left_bands_sent};
            msld_pkg::REG_RIGHT_BANDS_SENT:
                prdata = {{(msld_pkg::ApbDataW-msld_pkg::CntW){1'b0}}, r_right_bands_sent};
            msld_pkg::REG_MASK_MODE:
                prdata = {{(msld_pkg::ApbDataW-msld_pkg::ModeW){1'b0}}, r_mask_mode};
            default:
                prdata = '0;
        endcase
    end

    // clamped counts
    logic [msld_pkg::CntW-1:0] limit, nl, nr;
    assign limit = (r_ms_band_limit    > MaxBandsC) ? MaxBandsC : r_ms_band_limit;
    assign nl    = (r_left_bands_sent  > MaxBandsC) ? MaxBandsC : r_left_bands_sent;
    assign nr    = (r_right_bands_sent > MaxBandsC) ? MaxBandsC : r_right_bands_sent;

    // two-stage pipeline: input register, result register
    logic               r_in_valid;
    msld_pkg::t_in_item r_in;
    logic               r_out_valid;
    msld_pkg::t_out_item r_out;
    msld_pkg::t_out_item n_out;
    msld_pkg::t_in_item  in_item;

    logic advance;
    logic in_xfer;

    assign advance         = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;

    assign in_item.left_in    = i_s_axis_tdata[31:0];
    assign in_item.right_in   = i_s_axis_tdata[63:32];
    assign in_item.band_index = i_s_axis_tdata[69:64];
    assign in_item.left_exp   = i_s_axis_tdata[76:70];
    assign in_item.right_exp  = i_s_axis_tdata[83:77];
    assign in_item.ms_flag    = i_s_axis_tuser;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in <= in_item;
        end
        if (advance && r_in_valid) begin
            r_out <= n_out;
        end
    end

    // per-line decode
    logic [msld_pkg::ExpOutW-1:0] le8, re8, common;
    logic [msld_pkg::ExpOutW-1:0] ldiff, rdiff;
    logic [msld_pkg::ShiftW-1:0]  ls, rs;
    logic signed [msld_pkg::CoefW-1:0] a_sh, b_sh;
    logic [msld_pkg::CntW-1:0] band7;
    logic band_ok;

    assign le8    = {1'b0, r_in.left_exp};
    assign re8    = {1'b0, r_in.right_exp};
    assign common = ((le8 > re8) ? le8 : re8) + 8'd1;
    assign ldiff  = common - le8;
    assign rdiff  = common - re8;
    assign ls     = (ldiff > {3'b000, msld_pkg::ShiftMax}) ? msld_pkg::ShiftMax
                                                           : ldiff[msld_pkg::ShiftW-1:0];
    assign rs     = (rdiff > {3'b000, msld_pkg::ShiftMax}) ? msld_pkg::ShiftMax
                                                           : rdiff[msld_pkg::ShiftW-1:0];
    assign a_sh   = r_in.left_in >>> ls;
    assign b_sh   = r_in.right_in >>> rs;
    assign band7  = {1'b0, r_in.band_index};
    assign band_ok = (band7 < MaxBandsC) && r_in.ms_flag;

    always_comb begin
        n_out.left_out      = r_in.left_in;
        n_out.right_out     = r_in.right_in;
        n_out.left_exp_out  = le8;
        n_out.right_exp_out = re8;
        n_out.ms_flag_out   = r_in.ms_flag && (r_mask_mode != msld_pkg::MaskModeClear);
        if (band_ok) begin
            if (band7 < limit) begin
                n_out.left_out      = a_sh + b_sh;
                n_out.right_out     = a_sh - b_sh;
                n_out.left_exp_out  = common;
                n_out.right_exp_out = common;
            end else if (nl > nr) begin
                // right channel stopped early: copy left into it
                if (band7 < nl) begin
                    n_out.right_out     = r_in.left_in;
                    n_out.right_exp_out = le8;
                end
            end else if (nr > nl) begin
                if (band7 < nr) begin
                    n_out.left_out     = r_in.right_in;
                    n_out.right_out    = -r_in.right_in;
                    n_out.left_exp_out = re8;
                end
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out.right_exp_out, r_out.left_exp_out,
                              r_out.right_out, r_out.left_out};
    assign o_m_axis_tuser  = r_out.ms_flag_out;

endmodule

/* tb/tb.sv */
// Self-checking testbench for the mid/side stereo line decoder.
`timescale 1ns / 1ps

module tb;

    logic                          i_clk;
    logic                          i_rst_n = 1'b0;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [msld_pkg::AddrW-1:0]    paddr = '0;
    logic [msld_pkg::ApbDataW-1:0] pwdata = '0;
    logic [msld_pkg::ApbDataW-1:0] prdata;
    logic                          pready;
    logic                          i_s_axis_tvalid = 1'b0;
    logic                          o_s_axis_tready;
    // [31:0] left_in, [63:32] right_in, [69:64] band_index,
    // [76:70] left_exp, [83:77] right_exp, [87:84] zero
    logic [msld_pkg::InDataW-1:0]  i_s_axis_tdata = '0;
    // [0] ms_flag
    logic                          i_s_axis_tuser = 1'b0;
    logic                          o_m_axis_tvalid;
    logic                          i_m_axis_tready = 1'b0;
    // [31:0] left_out, [63:32] right_out, [71:64] left_exp_out,
    // [79:72] right_exp_out
    logic [msld_pkg::OutDataW-1:0] o_m_axis_tdata;
    // [0] ms_flag_out
    logic                          o_m_axis_tuser;

    ms_stereo_line_decode_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // shadow of the register file
    logic [msld_pkg::CntW-1:0]  cfg_limit = '0;
    logic [msld_pkg::CntW-1:0]  cfg_left_cnt = '0;
    logic [msld_pkg::CntW-1:0]  cfg_right_cnt = '0;
    logic [msld_pkg::ModeW-1:0] cfg_mode = '0;

    msld_pkg::t_in_item  line_q[$];
    msld_pkg::t_out_item decoded_q[$];
    msld_pkg::t_in_item  cur_line;
    msld_pkg::t_out_item want;
    int        err_cnt = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    bit        send_hold = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [msld_pkg::CntW-1:0] clamp_bands(logic [msld_pkg::CntW-1:0] v);
        return (v > 64) ? msld_pkg::CntW'(64) : v;
    endfunction

    // expected result for one line pair under the current register settings
    function automatic msld_pkg::t_out_item decode_line(msld_pkg::t_in_item it);
        logic [msld_pkg::CntW-1:0]         limit;
        logic [msld_pkg::CntW-1:0]         nl;
        logic [msld_pkg::CntW-1:0]         nr;
        logic [msld_pkg::ExpOutW-1:0]      common;
        logic [msld_pkg::ExpOutW-1:0]      lsh;
        logic [msld_pkg::ExpOutW-1:0]      rsh;
        logic signed [msld_pkg::CoefW-1:0] l;
        logic signed [msld_pkg::CoefW-1:0] r;
        logic signed [msld_pkg::CoefW-1:0] a;
        logic signed [msld_pkg::CoefW-1:0] b;
        msld_pkg::t_out_item               res;
        limit = clamp_bands(cfg_limit);
        nl = clamp_bands(cfg_left_cnt);
        nr = clamp_bands(cfg_right_cnt);
        l = it.left_in;
        r = it.right_in;
        res.left_out = l;
        res.right_out = r;
        res.left_exp_out = {1'b0, it.left_exp};
        res.right_exp_out = {1'b0, it.right_exp};
        res.ms_flag_out = it.ms_flag && (cfg_mode != msld_pkg::MaskModeClear);
        if (it.ms_flag) begin
            if ({1'b0, it.band_index} < limit) begin
                common = ((it.left_exp > it.right_exp) ? {1'b0, it.left_exp}
                                                       : {1'b0, it.right_exp}) + 8'd1;
                lsh = common - {1'b0, it.left_exp};
                rsh = common - {1'b0, it.right_exp};
                if (lsh > 8'd31) lsh = 8'd31;
                if (rsh > 8'd31) rsh = 8'd31;
                a = l >>> lsh[4:0];
                b = r >>> rsh[4:0];
                res.left_out = a + b;
                res.right_out = a - b;
                res.left_exp_out = common;
                res.right_exp_out = common;
            end else if (nl > nr) begin
                if ({1'b0, it.band_index} < nl) begin
                    res.right_out = l;
                    res.right_exp_out = {1'b0, it.left_exp};
                end
            end else if (nr > nl) begin
                if ({1'b0, it.band_index} < nr) begin
                    res.left_out = r;
                    res.right_out = -r;
                    res.left_exp_out = {1'b0, it.right_exp};
                end
            end
        end
        return res;
    endfunction

    // input side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                decoded_q.push_back(decode_line(cur_line));
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (line_q.size() != 0 && !send_hold &&
                    $urandom_range(0, 99) >= send_idle_pct) begin
                    cur_line = line_q.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata <= {4'b0, cur_line.right_exp, cur_line.left_exp,
                                       cur_line.band_index, cur_line.right_in,
                                       cur_line.left_in};
                    i_s_axis_tuser <= cur_line.ms_flag;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic void check_field(string name, logic [31:0] want_v,
                                        logic [31:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
            err_cnt++;
        end
    endfunction

    // result side
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (decoded_q.size() == 0) begin
                $error("result transfer with nothing outstanding");
                err_cnt++;
            end else begin
                want = decoded_q.pop_front();
                check_field("left_out", want.left_out, o_m_axis_tdata[31:0]);
                check_field("right_out", want.right_out, o_m_axis_tdata[63:32]);
                check_field("left_exp_out", 32'(want.left_exp_out),
                            32'(o_m_axis_tdata[71:64]));
                check_field("right_exp_out", 32'(want.right_exp_out),
                            32'(o_m_axis_tdata[79:72]));
                check_field("ms_flag_out", 32'(want.ms_flag_out), 32'(o_m_axis_tuser));
            end
        end
    end

    task automatic wait_idle();
        do @(negedge i_clk);
        while (line_q.size() != 0 || i_s_axis_tvalid || decoded_q.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(msld_pkg::t_reg_idx idx, logic [msld_pkg::ApbDataW-1:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            msld_pkg::REG_MS_BAND_LIMIT:    cfg_limit = val[msld_pkg::CntW-1:0];
            msld_pkg::REG_LEFT_BANDS_SENT:  cfg_left_cnt = val[msld_pkg::CntW-1:0];
            msld_pkg::REG_RIGHT_BANDS_SENT: cfg_right_cnt = val[msld_pkg::CntW-1:0];
            msld_pkg::REG_MASK_MODE:        cfg_mode = val[msld_pkg::ModeW-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(int limit, int nl, int nr, int mode);
        wait_idle();
        write_reg(msld_pkg::REG_MS_BAND_LIMIT, limit);
        write_reg(msld_pkg::REG_LEFT_BANDS_SENT, nl);
        write_reg(msld_pkg::REG_RIGHT_BANDS_SENT, nr);
        write_reg(msld_pkg::REG_MASK_MODE, mode);
        @(negedge i_clk);
    endtask

    task automatic add_line(logic [31:0] l, logic [31:0] r,
                            logic [msld_pkg::BandW-1:0] band,
                            logic [msld_pkg::ExpW-1:0] le, logic [msld_pkg::ExpW-1:0] re,
                            logic flag);
        msld_pkg::t_in_item it;
        it.left_in = l;
        it.right_in = r;
        it.band_index = band;
        it.left_exp = le;
        it.right_exp = re;
        it.ms_flag = flag;
        line_q.push_back(it);
    endtask

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0;
            3:       return 32'hffff_ffff;
            4:       return 32'($urandom_range(0, 255)) - 32'd128;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [msld_pkg::ExpW-1:0] rand_exp();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return msld_pkg::ExpW'($urandom_range(0, 127));
        endcase
    endfunction

    function automatic int rand_count();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 64;
            2:       return $urandom_range(65, 127);
            default: return $urandom_range(0, 64);
        endcase
    endfunction

    task automatic add_random_lines(int n);
        logic [msld_pkg::ExpW-1:0] le;
        for (int i = 0; i < n; i++) begin
            le = rand_exp();
            add_line(rand_coef(), rand_coef(), msld_pkg::BandW'($urandom_range(0, 63)), le,
                     ($urandom_range(0, 3) == 0) ? le : rand_exp(),
                     $urandom_range(0, 3) != 0);
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: mid/side with shift extremes, fill from left, pass-through
        set_config(16, 48, 32, 0);
        add_line(32'h7fff_ffff, 32'h7fff_ffff, 0, 127, 127, 1'b1);
        add_line(32'h8000_0000, 32'h8000_0000, 15, 0, 127, 1'b1);
        add_line(32'h8000_0000, 32'h7fff_ffff, 3, 127, 0, 1'b1);
        add_line(32'h1234_5678, 32'hfedc_ba98, 5, 10, 12, 1'b1);
        add_line(32'h7fff_ffff, 32'h8000_0000, 0, 0, 0, 1'b0);
        add_line(32'h8000_0000, 32'h1111_1111, 16, 127, 3, 1'b1);
        add_line(32'h7fff_ffff, 32'h2222_2222, 47, 0, 99, 1'b1);
        add_line(32'h3333_3333, 32'h4444_4444, 48, 5, 6, 1'b1);
        add_line(32'hffff_ffff, 32'h0000_0001, 63, 127, 127, 1'b1);
        // fill from right, negation of the most negative value, mode that clears flag
        set_config(0, 10, 64, 2);
        add_line(32'h5555_5555, 32'h8000_0000, 0, 3, 4, 1'b1);
        add_line(32'h0000_0000, 32'h7fff_ffff, 63, 0, 127, 1'b1);
        add_line(32'h0000_0007, 32'hffff_fff0, 9, 8, 9, 1'b0);
        add_line(32'h8000_0000, 32'h0000_0000, 20, 127, 0, 1'b1);
        // oversized registers act as 64, equal counts mean no fill
        set_config(127, 127, 100, 3);
        add_line(32'h8000_0000, 32'h7fff_ffff, 63, 0, 0, 1'b1);
        add_line(32'hffff_ffff, 32'h0000_0001, 0, 127, 127, 1'b1);
        add_line(32'h0bad_cafe, 32'hdead_beef, 31, 60, 61, 1'b0);
        set_config(0, 100, 5, 1);
        add_line(32'h8000_0000, 32'h7fff_ffff, 63, 127, 0, 1'b1);
        add_line(32'h0000_0001, 32'hffff_ffff, 4, 1, 2, 1'b1);
        add_line(32'h7fff_ffff, 32'h8000_0000, 0, 0, 127, 1'b0);

        for (int seg = 0; seg < 11; seg++) begin
            case (seg)
                0:       set_config(0, 0, 0, 0);
                1:       set_config(127, 127, 127, 3);
                2:       set_config(64, 0, 64, 2);
                3:       set_config(32, 64, 0, 1);
                default: set_config(rand_count(), rand_count(), rand_count(),
                                    $urandom_range(0, 3));
            endcase
            case (seg % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
                default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            if (seg == 5) begin
                add_random_lines(50);
                do @(negedge i_clk); while (line_q.size() != 0);
                // hold the next lines back until everything sent so far has drained
                send_hold = 1'b1;
                add_random_lines(50);
                do @(negedge i_clk); while (i_s_axis_tvalid || decoded_q.size() != 0);
                send_hold = 1'b0;
            end else begin
                add_random_lines(100);
            end
        end

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
